// ===== hw/rtl/mfp_pkg.sv =====
// Shared types and constants for the motion-capture frame parser.
// No dependencies; every other file of the block but mfp_if imports this package.
package mfp_pkg;

	localparam int REC_LEN          = 13;
	localparam int REC_IDX_W        = $clog2(REC_LEN);
	localparam int PREFIX_BYTES_DEF = 7;
	localparam int QUEUE_DEPTH      = 2;
	localparam int MAG_W            = 23;
	localparam int VEL_W            = 24;
	localparam int DIV_CNT_W        = $clog2(MAG_W);
	localparam int CFG_IDX_W        = 2;

	localparam logic [7:0] OWN_ID_RST     = 8'd0;
	localparam logic [7:0] TARGET_ID_RST  = 8'd1;
	localparam logic [7:0] MAX_OBJ_RST    = 8'd16;

	localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_ID   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_OBJECTS = 2'd2;

	localparam logic KIND_OWN    = 1'b0;
	localparam logic KIND_TARGET = 1'b1;

	typedef logic signed [15:0]      coord_t;
	typedef logic signed [VEL_W-1:0] vel_t;

	typedef struct packed {
		logic        is_own;
		logic        is_tgt;
		logic [31:0] gap;
		coord_t [2:0] pos;
		coord_t [2:0] att;
	} rec_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic         kind;
		coord_t [2:0] pos;
		coord_t [2:0] att;
		vel_t [2:0]   vel;
		logic         last_of_run;
	} result_t;

	typedef enum logic [2:0] {
		BE_IDLE,
		BE_LOAD,
		BE_DIV,
		BE_EMIT_OWN,
		BE_EMIT_TGT
	} be_state_t;

endpackage

// ===== hw/rtl/mfp_if.sv =====
// Channel interfaces of the frame parser: byte input, result output, register writes.
// No dependencies.
interface mfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       start_of_datagram;
	modport source(output valid, data_byte, start_of_datagram, input ready);
	modport sink(input valid, data_byte, start_of_datagram, output ready);
endinterface

interface mfp_result_if;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [15:0]        pos_x;
	logic signed [15:0]        pos_y;
	logic signed [15:0]        pos_z;
	logic signed [15:0]        roll;
	logic signed [15:0]        pitch;
	logic signed [15:0]        yaw;
	logic signed [23:0]        vel_x;
	logic signed [23:0]        vel_y;
	logic signed [23:0]        vel_z;
	logic                      last_of_run;
	modport source(output valid, kind, pos_x, pos_y, pos_z, roll, pitch, yaw,
		vel_x, vel_y, vel_z, last_of_run, input ready);
	modport sink(input valid, kind, pos_x, pos_y, pos_z, roll, pitch, yaw,
		vel_x, vel_y, vel_z, last_of_run, output ready);
endinterface

interface mfp_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/mfp_front.sv =====
// Front end: walks the datagram bytes, checks frame number and object count,
// collects records and pushes matching ones into the queue. Depends on mfp_pkg and mfp_if.
module mfp_front #(
	parameter int PREFIX_BYTES = mfp_pkg::PREFIX_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	mfp_byte_if.sink            byte_in,
	input  logic [7:0]          own_id,
	input  logic [7:0]          target_id,
	input  logic [7:0]          max_objects,
	input  mfp_pkg::q_stat_t    q_stat,
	output logic                push,
	output mfp_pkg::rec_entry_t push_entry
);
	import mfp_pkg::*;

	localparam int COUNT_POS = PREFIX_BYTES + 4;
	localparam int REC_POS   = PREFIX_BYTES + 5;
	localparam int POS_W     = $clog2(REC_POS + REC_LEN + 1);

	logic [POS_W-1:0]     pos_q, pos_eff, pos_d;
	logic                 drop_q, drop_eff, drop_d;
	logic [31:0]          last_frame_q, gap_q, frame_q, frame_new;
	logic [7:0]           objects_left_q;
	logic [7:0]           rec_q [REC_LEN-1];
	logic [REC_IDX_W-1:0] rec_k;
	logic                 accept, b_zero;
	logic                 frame_byte, frame_ok, count_ok, rec_byte, rec_done;
	logic [7:0]           b;

	assign b              = byte_in.data_byte;
	assign b_zero         = (b == 8'd0);
	assign byte_in.ready  = !q_stat.full;
	assign accept         = byte_in.valid && byte_in.ready;
	assign frame_new      = {b, frame_q[31:8]};

	always_comb begin
		drop_eff   = byte_in.start_of_datagram ? 1'b0 : drop_q;
		pos_eff    = byte_in.start_of_datagram ? '0 : pos_q;
		rec_k      = REC_IDX_W'(pos_eff - POS_W'(REC_POS));
		pos_d      = pos_q;
		drop_d     = drop_q;
		frame_byte = 1'b0;
		frame_ok   = 1'b0;
		count_ok   = 1'b0;
		rec_byte   = 1'b0;
		rec_done   = 1'b0;
		if (accept) begin
			pos_d  = pos_eff;
			drop_d = drop_eff;
			if (!drop_eff) begin
				if (pos_eff < POS_W'(PREFIX_BYTES)) begin
					pos_d = pos_eff + 1'b1;
				end else if (pos_eff < POS_W'(COUNT_POS)) begin
					pos_d      = pos_eff + 1'b1;
					frame_byte = 1'b1;
					if (pos_eff == POS_W'(COUNT_POS - 1)) begin
						if (frame_new <= last_frame_q) drop_d = 1'b1;
						else frame_ok = 1'b1;
					end
				end else if (pos_eff == POS_W'(COUNT_POS)) begin
					if (b > max_objects || b_zero) begin
						drop_d = 1'b1;
					end else begin
						pos_d    = pos_eff + 1'b1;
						count_ok = 1'b1;
					end
				end else if (rec_k == REC_IDX_W'(REC_LEN - 1)) begin
					rec_done = 1'b1;
					pos_d    = POS_W'(REC_POS);
					if (objects_left_q <= 8'd1) drop_d = 1'b1;
				end else begin
					rec_byte = 1'b1;
					pos_d    = pos_eff + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			drop_q         <= 1'b1;
			last_frame_q   <= '0;
			gap_q          <= '0;
			objects_left_q <= '0;
		end else begin
			pos_q  <= pos_d;
			drop_q <= drop_d;
			if (frame_ok) begin
				gap_q        <= frame_new - last_frame_q;
				last_frame_q <= frame_new;
			end
			if (count_ok) objects_left_q <= b;
			else if (rec_done && objects_left_q != 8'd0) objects_left_q <= objects_left_q - 8'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_byte) frame_q <= frame_new;
		if (rec_byte) rec_q[rec_k] <= b;
	end

	// The record's last byte goes straight into the queue entry.
	always_comb begin
		push_entry.is_own = (rec_q[0] == own_id);
		push_entry.is_tgt = (rec_q[0] == target_id);
		push_entry.gap    = gap_q;
		push_entry.pos[0] = {rec_q[2], rec_q[1]};
		push_entry.pos[1] = {rec_q[4], rec_q[3]};
		push_entry.pos[2] = {rec_q[6], rec_q[5]};
		push_entry.att[0] = {rec_q[8], rec_q[7]};
		push_entry.att[1] = {rec_q[10], rec_q[9]};
		push_entry.att[2] = {b, rec_q[11]};
	end

	assign push = rec_done && (push_entry.is_own || push_entry.is_tgt);

endmodule

// ===== hw/rtl/mfp_queue.sv =====
// Short record queue between front end and back end.
// Depends on mfp_pkg.
module mfp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  mfp_pkg::rec_entry_t push_entry,
	input  logic                pop,
	output mfp_pkg::rec_entry_t pop_entry,
	output mfp_pkg::q_stat_t    q_stat
);
	import mfp_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	rec_entry_t       mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign q_stat.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign pop_entry    = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= ptr_inc(wr_q);
			if (pop) rd_q <= ptr_inc(rd_q);
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

endmodule

// ===== hw/rtl/mfp_back.sv =====
// Back end: velocity through one shared bit-serial divider, result register.
// Depends on mfp_pkg and mfp_if.
module mfp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mfp_pkg::q_stat_t    q_stat,
	output logic                pop,
	input  mfp_pkg::rec_entry_t pop_entry,
	mfp_result_if.source        result
);
	import mfp_pkg::*;

	be_state_t            state_q, state_d;
	rec_entry_t           ent_q;
	logic [1:0]           axis_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [31:0]          rem_q, rem_next;
	logic [MAG_W-1:0]     quo_q, quo_next;
	logic                 neg_q;
	vel_t [2:0]           vel_q;
	coord_t [2:0]         prev_q;
	result_t              res_q;
	logic                 res_valid_q;
	logic                 out_free, load_go, div_step, div_last, emit_own, emit_tgt;
	logic signed [16:0]   diff;
	logic signed [23:0]   num;
	logic [32:0]          trial;
	logic                 ge;
	vel_t                 vel_new;

	assign out_free = !res_valid_q || result.ready;
	assign div_last = (cnt_q == DIV_CNT_W'(MAG_W - 1));

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_go  = 1'b0;
		div_step = 1'b0;
		emit_own = 1'b0;
		emit_tgt = 1'b0;
		case (state_q)
			BE_IDLE: begin
				if (!q_stat.empty) begin
					pop     = 1'b1;
					state_d = pop_entry.is_own ? BE_LOAD : BE_EMIT_TGT;
				end
			end
			BE_LOAD: begin
				load_go = 1'b1;
				state_d = BE_DIV;
			end
			BE_DIV: begin
				div_step = 1'b1;
				if (div_last) state_d = (axis_q == 2'd2) ? BE_EMIT_OWN : BE_LOAD;
			end
			BE_EMIT_OWN: begin
				if (out_free) begin
					emit_own = 1'b1;
					state_d  = ent_q.is_tgt ? BE_EMIT_TGT : BE_IDLE;
				end
			end
			BE_EMIT_TGT: begin
				if (out_free) begin
					emit_tgt = 1'b1;
					state_d  = BE_IDLE;
				end
			end
			default: state_d = BE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BE_IDLE;
			res_valid_q <= 1'b0;
			prev_q      <= '0;
		end else begin
			state_q <= state_d;
			if (emit_own || emit_tgt) res_valid_q <= 1'b1;
			else if (result.ready) res_valid_q <= 1'b0;
			if (emit_own) prev_q <= ent_q.pos;
		end
	end

	// Difference times 120 as (d << 7) - (d << 3); magnitude fits in 23 bits.
	always_comb begin
		diff = 17'($signed(ent_q.pos[axis_q])) - 17'($signed(prev_q[axis_q]));
		num  = ($signed({{7{diff[16]}}, diff}) <<< 7) - ($signed({{7{diff[16]}}, diff}) <<< 3);
	end

	// One restoring step a cycle.
	always_comb begin
		trial    = {rem_q, quo_q[MAG_W-1]};
		ge       = (trial >= {1'b0, ent_q.gap});
		rem_next = ge ? 32'(trial - {1'b0, ent_q.gap}) : trial[31:0];
		quo_next = {quo_q[MAG_W-2:0], ge};
		if (ent_q.gap == 32'd0) vel_new = '0;
		else if (neg_q) vel_new = -$signed({1'b0, quo_next});
		else vel_new = $signed({1'b0, quo_next});
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			ent_q  <= pop_entry;
			axis_q <= '0;
		end
		if (load_go) begin
			neg_q <= num[23];
			quo_q <= num[23] ? MAG_W'(-num) : num[MAG_W-1:0];
			rem_q <= '0;
			cnt_q <= '0;
		end
		if (div_step) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
			cnt_q <= cnt_q + 1'b1;
			if (div_last) begin
				vel_q[axis_q] <= vel_new;
				axis_q        <= axis_q + 2'd1;
			end
		end
		if (emit_own) begin
			res_q.kind        <= KIND_OWN;
			res_q.pos         <= ent_q.pos;
			res_q.att         <= ent_q.att;
			res_q.vel         <= vel_q;
			res_q.last_of_run <= !ent_q.is_tgt;
		end
		if (emit_tgt) begin
			res_q.kind        <= KIND_TARGET;
			res_q.pos         <= ent_q.pos;
			res_q.att         <= '0;
			res_q.vel         <= '0;
			res_q.last_of_run <= 1'b1;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.kind        = res_q.kind;
	assign result.pos_x       = res_q.pos[0];
	assign result.pos_y       = res_q.pos[1];
	assign result.pos_z       = res_q.pos[2];
	assign result.roll        = res_q.att[0];
	assign result.pitch       = res_q.att[1];
	assign result.yaw         = res_q.att[2];
	assign result.vel_x       = res_q.vel[0];
	assign result.vel_y       = res_q.vel[1];
	assign result.vel_z       = res_q.vel[2];
	assign result.last_of_run = res_q.last_of_run;

endmodule

// ===== hw/rtl/mocap_frame_parser.sv =====
// Top level of the motion-capture frame parser: registers, front end, queue, back end.
// Depends on mfp_pkg, mfp_if, mfp_front, mfp_queue and mfp_back.
//
//   Channel   Direction  Payload
//   byte_in   in         data_byte[7:0], start_of_datagram
//   result    out        kind, pos_x/y/z, roll/pitch/yaw, vel_x/y/z, last_of_run
//   cfg       in         index[1:0], data[7:0]
//
// The front end takes one byte a cycle while the queue is not full. A record that matches
// neither id costs nothing beyond its 13 bytes. A record for the own id is popped, then
// loaded and divided on the shared one-bit-a-cycle divider once for each of the three axes,
// then emits one result per id it matches. A target-only record goes straight to its emit.
// Byte input stalls only while the two-entry record queue is full; the result register
// lets the back end load a new result in the same cycle the old one is transferred.
// Reset is asynchronous and active low; after reset bytes are ignored until a start byte.
module mocap_frame_parser #(
	parameter int PREFIX_BYTES = mfp_pkg::PREFIX_BYTES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	mfp_byte_if.sink     byte_in,
	mfp_result_if.source result,
	mfp_cfg_if.sink      cfg
);
	import mfp_pkg::*;

	logic [7:0] own_id_q, target_id_q, max_objects_q;
	logic       push, pop;
	rec_entry_t push_entry, pop_entry;
	q_stat_t    q_stat;

	// Registers are to be written only while idle; the block does not check this. Writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q      <= OWN_ID_RST;
			target_id_q   <= TARGET_ID_RST;
			max_objects_q <= MAX_OBJ_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_OWN_ID:      own_id_q      <= cfg.data;
				CFG_TARGET_ID:   target_id_q   <= cfg.data;
				CFG_MAX_OBJECTS: max_objects_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Front end: byte walk, frame and count checks, record assembly.
	mfp_front #(
		.PREFIX_BYTES(PREFIX_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_in),
		.own_id     (own_id_q),
		.target_id  (target_id_q),
		.max_objects(max_objects_q),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	// Matching records wait here, with the frame gap they were seen under.
	mfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.pop_entry (pop_entry),
		.q_stat    (q_stat)
	);

	// Back end: velocity divisions and the result register.
	mfp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop      (pop),
		.pop_entry(pop_entry),
		.result   (result)
	);

	// A record is never pushed into a full queue.
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_stat.full)
		else $error("record pushed into full queue");

	// The back end never pops an empty queue.
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !q_stat.empty)
		else $error("record popped from empty queue");

	// Target results carry no velocity and a zero roll, and close their run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.kind == KIND_TARGET) |->
		(result.vel_x == '0 && result.vel_y == '0 && result.vel_z == '0 &&
		 result.roll == '0 && result.last_of_run))
		else $error("target result with attitude or velocity");

endmodule
